>>> rtl/dcma_pkg.sv
// Shared types and constants for the drive command mode arbiter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dcma_pkg;

   localparam int ID_WIDTH        = 11;
   localparam int THRESH_WIDTH    = 7;
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH  = 11;
   localparam int SETPOINT_WIDTH  = 8;
   localparam int THROTTLE_WIDTH  = 9;
   localparam int FULL_SCALE      = 100;
   localparam int BRAKE_MARK      = 200;

   localparam logic [7:0] MODE_CODE_AUTO   = 8'd0;
   localparam logic [7:0] MODE_CODE_MANUAL = 8'd1;
   localparam logic [7:0] MODE_CODE_DEBUG  = 8'd2;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_MODE_ID   = 3'd0,
      CSR_AI_ID     = 3'd1,
      CSR_JOY_ID    = 3'd2,
      CSR_PARK_ID   = 3'd3,
      CSR_THRESHOLD = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      DRIVE_MANUAL = 2'd0,
      DRIVE_AUTO   = 2'd1,
      DRIVE_DEBUG  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      CODE_TO_AUTO   = 2'd0,
      CODE_TO_MANUAL = 2'd1,
      CODE_TO_DEBUG  = 2'd2,
      CODE_UNKNOWN   = 2'd3
   } mode_code_type;

   typedef struct packed {
      logic                               is_tick;
      logic                               hit_mode;
      logic                               hit_ai;
      logic                               hit_joy;
      logic                               hit_park;
      mode_code_type                      code;
      logic signed [THROTTLE_WIDTH-1:0]   throttle;
      logic signed [SETPOINT_WIDTH-1:0]   steering;
      logic                               over;
   } cmd_type;

   typedef struct packed {
      logic                               drive_valid;
      logic signed [SETPOINT_WIDTH-1:0]   throttle;
      logic signed [SETPOINT_WIDTH-1:0]   steering;
      logic                               brake;
      mode_type                           mode;
      logic                               ctrl_reset;
      logic                               assist;
      logic                               park;
   } rsp_type;

endpackage

>>> rtl/dcma_front.sv
// Front end: holds the identifier and threshold registers, matches frame ids,
// decodes and clamps the targets of each request. Depends on dcma_pkg.
`timescale 1ns / 1ps

module dcma_front
   import dcma_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_ADDR_WIDTH-1:0]  csr_addr,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                       is_tick,
   input  logic [ID_WIDTH-1:0]        can_id,
   input  logic [7:0]                 payload_b0,
   input  logic [7:0]                 payload_b1,
   input  logic [7:0]                 payload_b2,
   input  logic [7:0]                 payload_b3,
   output cmd_type                    cmd
);

   localparam logic signed [15:0] SAT_HI    = 16'(FULL_SCALE);
   localparam logic signed [15:0] SAT_LO    = -SAT_HI;
   localparam logic signed [15:0] BRAKE_RAW = 16'(BRAKE_MARK);

   logic [ID_WIDTH-1:0]      mode_id_ff, mode_id_in;
   logic [ID_WIDTH-1:0]      ai_id_ff, ai_id_in;
   logic [ID_WIDTH-1:0]      joy_id_ff, joy_id_in;
   logic [ID_WIDTH-1:0]      park_id_ff, park_id_in;
   logic [THRESH_WIDTH-1:0]  thresh_ff, thresh_in;

   logic signed [15:0]                raw_thr;
   logic signed [15:0]                raw_ste;
   logic signed [SETPOINT_WIDTH-1:0]  sat_thr;
   logic signed [SETPOINT_WIDTH-1:0]  sat_ste;
   logic signed [THROTTLE_WIDTH-1:0]  thr;
   logic signed [THROTTLE_WIDTH-1:0]  neg_thr;
   logic [7:0]                        mag_thr;
   logic [7:0]                        mag_ste;

   function automatic logic signed [SETPOINT_WIDTH-1:0] sat_full(input logic signed [15:0] v);
      logic signed [SETPOINT_WIDTH-1:0] r;
      if (v > SAT_HI) begin
         r = SETPOINT_WIDTH'(SAT_HI);
      end else if (v < SAT_LO) begin
         r = SETPOINT_WIDTH'(SAT_LO);
      end else begin
         r = v[SETPOINT_WIDTH-1:0];
      end
      return r;
   endfunction

   always_comb begin
      mode_id_in = mode_id_ff;
      ai_id_in   = ai_id_ff;
      joy_id_in  = joy_id_ff;
      park_id_in = park_id_ff;
      thresh_in  = thresh_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_MODE_ID:   mode_id_in = csr_wdata[ID_WIDTH-1:0];
            CSR_AI_ID:     ai_id_in   = csr_wdata[ID_WIDTH-1:0];
            CSR_JOY_ID:    joy_id_in  = csr_wdata[ID_WIDTH-1:0];
            CSR_PARK_ID:   park_id_in = csr_wdata[ID_WIDTH-1:0];
            CSR_THRESHOLD: thresh_in  = csr_wdata[THRESH_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_id_ff <= ID_WIDTH'(0);
         ai_id_ff   <= ID_WIDTH'(1);
         joy_id_ff  <= ID_WIDTH'(2);
         park_id_ff <= ID_WIDTH'(3);
         thresh_ff  <= THRESH_WIDTH'(5);
      end else begin
         mode_id_ff <= mode_id_in;
         ai_id_ff   <= ai_id_in;
         joy_id_ff  <= joy_id_in;
         park_id_ff <= park_id_in;
         thresh_ff  <= thresh_in;
      end
   end

   always_comb begin
      raw_thr = signed'({payload_b1, payload_b0});
      raw_ste = signed'({payload_b3, payload_b2});
      sat_thr = sat_full(raw_thr);
      sat_ste = sat_full(raw_ste);
      thr     = (raw_thr == BRAKE_RAW) ? THROTTLE_WIDTH'(BRAKE_RAW)
                                       : {sat_thr[SETPOINT_WIDTH-1], sat_thr};
      neg_thr = -thr;
      mag_thr = thr[THROTTLE_WIDTH-1] ? neg_thr[7:0] : thr[7:0];
      mag_ste = sat_ste[SETPOINT_WIDTH-1] ? 8'(-sat_ste) : 8'(sat_ste);

      cmd.is_tick  = is_tick;
      cmd.hit_mode = (can_id == mode_id_ff);
      cmd.hit_ai   = (can_id == ai_id_ff);
      cmd.hit_joy  = (can_id == joy_id_ff);
      cmd.hit_park = (can_id == park_id_ff);
      case (payload_b0)
         MODE_CODE_AUTO:   cmd.code = CODE_TO_AUTO;
         MODE_CODE_MANUAL: cmd.code = CODE_TO_MANUAL;
         MODE_CODE_DEBUG:  cmd.code = CODE_TO_DEBUG;
         default:          cmd.code = CODE_UNKNOWN;
      endcase
      cmd.throttle = thr;
      cmd.steering = sat_ste;
      cmd.over     = (mag_thr > {1'b0, thresh_ff}) || (mag_ste > {1'b0, thresh_ff});
   end

endmodule

>>> rtl/dcma_queue.sv
// Short flop-based queue of classified requests between front and back end.
// Depends on dcma_pkg.
`timescale 1ns / 1ps

module dcma_queue
   import dcma_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  cmd_type  push_cmd,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output cmd_type  head_cmd
);

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   cmd_type                entry_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;

   always_comb begin
      full       = (count_ff == CNT_WIDTH'(DEPTH));
      head_valid = (count_ff != '0);
      head_cmd   = entry_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/dcma_back.sv
// Back end: applies queued requests to the drive mode and setpoint state and
// holds the result in an output register. Depends on dcma_pkg.
`timescale 1ns / 1ps

module dcma_back
   import dcma_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     head_valid,
   input  cmd_type  head_cmd,
   output logic     pop,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp
);

   localparam logic signed [THROTTLE_WIDTH-1:0] BRAKE_VAL = THROTTLE_WIDTH'(BRAKE_MARK);

   mode_type                          mode_ff, mode_in;
   logic signed [THROTTLE_WIDTH-1:0]  thr_ff, thr_in;
   logic signed [SETPOINT_WIDTH-1:0]  ste_ff, ste_in;
   logic                              armed_ff, armed_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   rsp_type                           rsp_ff, rsp_in;
   logic                              claimed;

   assign pop       = head_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      mode_in      = mode_ff;
      thr_in       = thr_ff;
      ste_in       = ste_ff;
      armed_in     = armed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      claimed      = 1'b0;
      rsp_in       = '0;

      if (pop) begin
         rsp_valid_in = 1'b1;
         if (!head_cmd.is_tick) begin
            if (head_cmd.hit_mode) begin
               case (head_cmd.code)
                  CODE_TO_AUTO: mode_in = DRIVE_AUTO;
                  CODE_TO_MANUAL: begin
                     mode_in = DRIVE_MANUAL;
                     thr_in  = '0;
                  end
                  CODE_TO_DEBUG: begin
                     mode_in = DRIVE_DEBUG;
                     thr_in  = '0;
                  end
                  default: mode_in = DRIVE_MANUAL;
               endcase
               rsp_in.ctrl_reset = 1'b1;
               claimed           = 1'b1;
            end else if (head_cmd.hit_ai && mode_ff == DRIVE_AUTO) begin
               thr_in = head_cmd.throttle;
               ste_in = head_cmd.steering;
               if (armed_ff) begin
                  rsp_in.ctrl_reset = 1'b1;
                  rsp_in.assist     = 1'b1;
                  armed_in          = 1'b0;
               end
               claimed = 1'b1;
            end else if (head_cmd.hit_joy) begin
               if (mode_ff == DRIVE_AUTO) begin
                  if (head_cmd.over) begin
                     mode_in           = DRIVE_MANUAL;
                     rsp_in.ctrl_reset = 1'b1;
                     thr_in            = head_cmd.throttle;
                     ste_in            = head_cmd.steering;
                     armed_in          = 1'b1;
                  end
               end else if (mode_ff == DRIVE_MANUAL) begin
                  thr_in   = head_cmd.throttle;
                  ste_in   = head_cmd.steering;
                  armed_in = 1'b1;
               end
               claimed = 1'b1;
            end else if (head_cmd.hit_park) begin
               rsp_in.park = 1'b1;
               claimed     = 1'b1;
            end
         end

         if (!claimed) begin
            if (thr_in == BRAKE_VAL) begin
               thr_in       = '0;
               rsp_in.brake = 1'b1;
            end
            rsp_in.drive_valid = 1'b1;
            rsp_in.throttle    = thr_in[SETPOINT_WIDTH-1:0];
            rsp_in.steering    = ste_in;
         end
         rsp_in.mode = mode_in;
      end else begin
         rsp_in = rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= DRIVE_MANUAL;
         thr_ff       <= '0;
         ste_ff       <= '0;
         armed_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         thr_ff       <= thr_in;
         ste_ff       <= ste_in;
         armed_ff     <= armed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

>>> rtl/drive_command_mode_arbiter_unit.sv
// Top level of the drive command mode arbiter: stream ports, front end, queue
// and back end. Depends on dcma_pkg, dcma_front, dcma_queue, dcma_back.
`timescale 1ns / 1ps

// Takes one request per clock cycle while req_tready is high, a CAN frame or a
// control tick, and gives one response per request in order. A request is
// matched and decoded combinationally, stored in the request queue when
// accepted, and applied to the mode and setpoint state once it heads the queue
// and the output register is free or being read. The queue of QUEUE_DEPTH
// entries and the single output register let the request side keep accepting
// while a response waits for rsp_tready. The identifier and threshold registers
// must be written by the user through csr_* while no request is in flight; unchecked.
module drive_command_mode_arbiter_unit
   import dcma_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_ADDR_WIDTH-1:0]  csr_addr,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // [10:0] can_id, [18:11] payload_b0, [26:19] payload_b1,
   // [34:27] payload_b2, [42:35] payload_b3, [47:43] zero
   input  logic [47:0]                req_tdata,
   // [0] op
   input  logic [0:0]                 req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // [7:0] throttle_out, [15:8] steering_out, [16] brake_active,
   // [18:17] mode_out, [19] controller_reset, [20] assist_request,
   // [21] parking_request, [23:22] zero
   output logic [23:0]                rsp_tdata,
   // [0] drive_valid
   output logic [0:0]                 rsp_tuser
);

   cmd_type  front_cmd;
   cmd_type  head_cmd;
   rsp_type  rsp;
   logic     queue_full;
   logic     head_valid;
   logic     pop;
   logic     push;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   dcma_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .is_tick    (req_tuser[0]),
      .can_id     (req_tdata[10:0]),
      .payload_b0 (req_tdata[18:11]),
      .payload_b1 (req_tdata[26:19]),
      .payload_b2 (req_tdata[34:27]),
      .payload_b3 (req_tdata[42:35]),
      .cmd        (front_cmd)
   );

   dcma_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (front_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   dcma_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tuser = rsp.drive_valid;
   assign rsp_tdata = {2'b00, rsp.park, rsp.assist, rsp.ctrl_reset, rsp.mode,
                       rsp.brake, rsp.steering, rsp.throttle};

endmodule

>>> verif/drive_command_checker.sv
// Checker for the drive command mode arbiter: predicts each response from the accepted
// requests and register writes, then compares the responses field by field.
// Depends on dcma_pkg.
`timescale 1ns / 1ps

module drive_command_checker
   import dcma_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_ADDR_WIDTH-1:0]  csr_addr,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   // [10:0] can_id, [18:11] payload_b0, [26:19] payload_b1,
   // [34:27] payload_b2, [42:35] payload_b3, [47:43] zero
   input  logic [47:0]                req_tdata,
   // [0] op
   input  logic [0:0]                 req_tuser,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // [7:0] throttle_out, [15:8] steering_out, [16] brake_active,
   // [18:17] mode_out, [19] controller_reset, [20] assist_request,
   // [21] parking_request, [23:22] zero
   input  logic [23:0]                rsp_tdata,
   // [0] drive_valid
   input  logic [0:0]                 rsp_tuser,
   output int                         mismatch_count,
   output int                         commands_pending
);

   logic [ID_WIDTH-1:0]             mode_id;
   logic [ID_WIDTH-1:0]             ai_id;
   logic [ID_WIDTH-1:0]             joy_id;
   logic [ID_WIDTH-1:0]             park_id;
   logic [THRESH_WIDTH-1:0]         threshold;
   mode_type                        mode;
   logic signed [THROTTLE_WIDTH-1:0] throttle_sp;
   logic signed [SETPOINT_WIDTH-1:0] steering_sp;
   logic                            assist_armed;
   rsp_type                         expected_commands[$];

   function automatic int clamp_full_scale(input int value);
      if (value > FULL_SCALE) return FULL_SCALE;
      if (value < -FULL_SCALE) return -FULL_SCALE;
      return value;
   endfunction

   function automatic int magnitude(input int value);
      return (value < 0) ? -value : value;
   endfunction

   task automatic decode_targets(input logic [47:0] data,
                                 output logic signed [THROTTLE_WIDTH-1:0] thr,
                                 output logic signed [SETPOINT_WIDTH-1:0] ste);
      logic signed [15:0] raw_thr;
      logic signed [15:0] raw_ste;
      raw_thr = data[26:11];
      raw_ste = data[42:27];
      ste = SETPOINT_WIDTH'(clamp_full_scale(raw_ste));
      // brake marker is kept as is, never saturated
      thr = THROTTLE_WIDTH'((raw_thr == BRAKE_MARK) ? BRAKE_MARK : clamp_full_scale(raw_thr));
   endtask

   task automatic arbitrate_request(input logic is_tick, input logic [47:0] data,
                                    output rsp_type cmd);
      logic [ID_WIDTH-1:0]              id;
      logic [7:0]                       code;
      logic                             claimed;
      logic signed [THROTTLE_WIDTH-1:0] joy_thr;
      logic signed [SETPOINT_WIDTH-1:0] joy_ste;
      id = data[10:0];
      code = data[18:11];
      cmd = '0;
      claimed = 1'b0;
      if (!is_tick) begin
         if (id == mode_id) begin
            case (code)
               MODE_CODE_AUTO: mode = DRIVE_AUTO;
               MODE_CODE_MANUAL: begin
                  mode = DRIVE_MANUAL;
                  throttle_sp = '0;
               end
               MODE_CODE_DEBUG: begin
                  mode = DRIVE_DEBUG;
                  throttle_sp = '0;
               end
               default: mode = DRIVE_MANUAL;
            endcase
            cmd.ctrl_reset = 1'b1;
            claimed = 1'b1;
         end else if (id == ai_id && mode == DRIVE_AUTO) begin
            decode_targets(data, throttle_sp, steering_sp);
            if (assist_armed) begin
               cmd.ctrl_reset = 1'b1;
               cmd.assist = 1'b1;
               assist_armed = 1'b0;
            end
            claimed = 1'b1;
         end else if (id == joy_id) begin
            if (mode == DRIVE_AUTO) begin
               decode_targets(data, joy_thr, joy_ste);
               if (magnitude(joy_thr) > int'(threshold) ||
                   magnitude(joy_ste) > int'(threshold)) begin
                  mode = DRIVE_MANUAL;
                  cmd.ctrl_reset = 1'b1;
                  throttle_sp = joy_thr;
                  steering_sp = joy_ste;
                  assist_armed = 1'b1;
               end
            end else if (mode == DRIVE_MANUAL) begin
               decode_targets(data, throttle_sp, steering_sp);
               assist_armed = 1'b1;
            end
            claimed = 1'b1;
         end else if (id == park_id) begin
            cmd.park = 1'b1;
            claimed = 1'b1;
         end
      end
      if (!claimed) begin
         cmd.drive_valid = 1'b1;
         if (throttle_sp == BRAKE_MARK) begin
            throttle_sp = '0;
            cmd.brake = 1'b1;
         end
         cmd.throttle = throttle_sp[SETPOINT_WIDTH-1:0];
         cmd.steering = steering_sp;
      end
      cmd.mode = mode;
   endtask

   task automatic compare_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         mode_id = 11'd0;
         ai_id = 11'd1;
         joy_id = 11'd2;
         park_id = 11'd3;
         threshold = 7'd5;
         mode = DRIVE_MANUAL;
         throttle_sp = '0;
         steering_sp = '0;
         assist_armed = 1'b1;
         expected_commands.delete();
         commands_pending <= 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_MODE_ID:   mode_id = csr_wdata[ID_WIDTH-1:0];
               CSR_AI_ID:     ai_id = csr_wdata[ID_WIDTH-1:0];
               CSR_JOY_ID:    joy_id = csr_wdata[ID_WIDTH-1:0];
               CSR_PARK_ID:   park_id = csr_wdata[ID_WIDTH-1:0];
               CSR_THRESHOLD: threshold = csr_wdata[THRESH_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            arbitrate_request(req_tuser[0], req_tdata, want);
            expected_commands.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_commands.size() == 0) begin
               $display("%0t: response expected none actual tuser %h tdata %h",
                        $time, rsp_tuser, rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_commands.pop_front();
               compare_field("drive_valid", want.drive_valid, rsp_tuser[0]);
               compare_field("throttle_out", $signed(want.throttle),
                             $signed(rsp_tdata[7:0]));
               compare_field("steering_out", $signed(want.steering),
                             $signed(rsp_tdata[15:8]));
               compare_field("brake_active", want.brake, rsp_tdata[16]);
               compare_field("mode_out", want.mode, rsp_tdata[18:17]);
               compare_field("controller_reset", want.ctrl_reset, rsp_tdata[19]);
               compare_field("assist_request", want.assist, rsp_tdata[20]);
               compare_field("parking_request", want.park, rsp_tdata[21]);
            end
         end
         commands_pending <= expected_commands.size();
      end
   end

endmodule

>>> verif/tb_drive_command_mode_arbiter_unit.sv
// Testbench top for the drive command mode arbiter: drives requests, register writes
// and response backpressure, and gives the verdict.
// Depends on dcma_pkg, drive_command_mode_arbiter_unit and drive_command_checker.
`timescale 1ns / 1ps

module tb_drive_command_mode_arbiter_unit;
   import dcma_pkg::*;

   localparam logic                      OP_FRAME       = 1'b0;
   localparam logic                      OP_TICK        = 1'b1;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_SPARE      = 3'd7;
   localparam int                        WATCHDOG_LIMIT = 2000;
   localparam int                        PHASE_ITEMS    = 108;
   localparam int                        SETTLE_CYCLES  = 4;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_we = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_addr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;
   logic                      req_tvalid = 1'b0;
   logic [47:0]               req_tdata = '0;
   logic [0:0]                req_tuser = '0;
   logic                      rsp_tready = 1'b0;
   wire                       req_tready;
   wire                       rsp_tvalid;
   wire  [23:0]               rsp_tdata;
   wire  [0:0]                rsp_tuser;
   int                        mismatch_count;
   int                        commands_pending;
   int                        idle_cycles = 0;
   logic                      quiet = 1'b0;
   logic [ID_WIDTH-1:0]       mode_id = 11'd0;
   logic [ID_WIDTH-1:0]       ai_id = 11'd1;
   logic [ID_WIDTH-1:0]       joy_id = 11'd2;
   logic [ID_WIDTH-1:0]       park_id = 11'd3;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   drive_command_mode_arbiter_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   drive_command_checker u_command_check (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .mismatch_count   (mismatch_count),
      .commands_pending (commands_pending)
   );

   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 8);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [7:0] random_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [ID_WIDTH-1:0] random_id();
      return ID_WIDTH'($urandom_range(0, 2047));
   endfunction

   function automatic logic [15:0] random_target();
      int v;
      case ($urandom_range(0, 7))
         0: v = BRAKE_MARK;
         1: v = int'($urandom_range(0, 20)) - 10;
         2: v = int'($urandom_range(0, 200)) - 100;
         3: v = $urandom_range(0, 65535);
         4: begin
            case ($urandom_range(0, 7))
               0: v = 32767;
               1: v = -32768;
               2: v = 101;
               3: v = -101;
               4: v = 199;
               5: v = 201;
               6: v = 100;
               default: v = -100;
            endcase
         end
         default: v = int'($urandom_range(0, 40)) - 20;
      endcase
      return v[15:0];
   endfunction

   task automatic send_request(input logic op, input logic [ID_WIDTH-1:0] id,
                               input logic [7:0] b0, input logic [7:0] b1,
                               input logic [7:0] b2, input logic [7:0] b3);
      int gap;
      gap = (!quiet && $urandom_range(0, 2) == 0) ? random_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {5'b0, b3, b2, b1, b0, id};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_targets(input logic [ID_WIDTH-1:0] id, input logic [15:0] thr,
                               input logic [15:0] ste);
      send_request(OP_FRAME, id, thr[7:0], thr[15:8], ste[7:0], ste[15:8]);
   endtask

   task automatic send_mode(input logic [7:0] code);
      send_request(OP_FRAME, mode_id, code, random_byte(), random_byte(), random_byte());
   endtask

   // hold off until every response is back and the pipeline is empty
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (commands_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      csr_we <= 1'b1;
      csr_addr <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [ID_WIDTH-1:0] m, input logic [ID_WIDTH-1:0] a,
                            input logic [ID_WIDTH-1:0] j, input logic [ID_WIDTH-1:0] p,
                            input logic [CSR_DATA_WIDTH-1:0] thr_word);
      drain();
      write_csr(CSR_MODE_ID, m);
      write_csr(CSR_AI_ID, a);
      write_csr(CSR_JOY_ID, j);
      write_csr(CSR_PARK_ID, p);
      write_csr(CSR_THRESHOLD, thr_word);
      mode_id = m;
      ai_id = a;
      joy_id = j;
      park_id = p;
   endtask

   task automatic random_request();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15)
         send_request(OP_TICK, random_id(), random_byte(), random_byte(), random_byte(),
                      random_byte());
      else if (r < 30)
         send_mode(($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 2)) : random_byte());
      else if (r < 55)
         send_targets(ai_id, random_target(), random_target());
      else if (r < 80)
         send_targets(joy_id, random_target(), random_target());
      else if (r < 88)
         send_request(OP_FRAME, park_id, random_byte(), random_byte(), random_byte(),
                      random_byte());
      else
         send_request(OP_FRAME, random_id(), random_byte(), random_byte(), random_byte(),
                      random_byte());
   endtask

   task automatic random_phase(input int count);
      for (int n = 0; n < count; n++) random_request();
   endtask

   initial begin : response_sink
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = random_gap() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      logic [ID_WIDTH-1:0] shared_id;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // manual mode, saturation and brake marker
      send_request(OP_TICK, 11'd0, 8'h00, 8'h00, 8'h00, 8'h00);
      send_targets(joy_id, 16'h7FFF, 16'h8000);
      send_request(OP_TICK, 11'd0, 8'h00, 8'h00, 8'h00, 8'h00);
      send_targets(joy_id, 16'(BRAKE_MARK), 16'd50);
      send_request(OP_TICK, 11'd0, 8'h00, 8'h00, 8'h00, 8'h00);
      send_request(OP_TICK, 11'h7FF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      // autonomy, assist kick, override
      send_mode(MODE_CODE_AUTO);
      send_targets(ai_id, -16'sd150, 16'd30);
      send_targets(ai_id, 16'd101, -16'sd101);
      send_request(OP_TICK, 11'd0, 8'h00, 8'h00, 8'h00, 8'h00);
      send_targets(joy_id, 16'd5, -16'sd5);
      send_request(OP_TICK, 11'd0, 8'h00, 8'h00, 8'h00, 8'h00);
      send_targets(joy_id, 16'd0, 16'd6);
      send_request(OP_TICK, 11'd0, 8'h00, 8'h00, 8'h00, 8'h00);
      send_mode(MODE_CODE_AUTO);
      send_targets(joy_id, 16'(BRAKE_MARK), 16'd0);
      send_request(OP_TICK, 11'd0, 8'h00, 8'h00, 8'h00, 8'h00);
      // debug mode, unknown codes, parking, unclaimed frames
      send_mode(MODE_CODE_DEBUG);
      send_targets(joy_id, 16'd80, 16'd80);
      send_targets(ai_id, 16'd40, 16'd40);
      send_mode(8'd3);
      send_mode(8'd255);
      send_request(OP_FRAME, park_id, 8'h00, 8'h00, 8'h00, 8'h00);
      send_request(OP_FRAME, 11'h7FF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_request(OP_TICK, 11'd0, 8'h00, 8'h00, 8'h00, 8'h00);

      configure(11'd100, 11'd200, 11'd300, 11'd400, 11'd0);
      random_phase(PHASE_ITEMS);

      configure(11'd2047, 11'd0, 11'd1, 11'd2046, 11'd100);
      random_phase(PHASE_ITEMS / 2);
      drain();
      random_phase(PHASE_ITEMS / 2);

      configure(11'd7, 11'd7, 11'd7, 11'd7, 11'h7FF);
      write_csr(CSR_SPARE, CSR_DATA_WIDTH'($urandom_range(0, 2047)));
      random_phase(PHASE_ITEMS);

      shared_id = random_id();
      configure(random_id(), shared_id, shared_id, random_id(),
                CSR_DATA_WIDTH'($urandom_range(0, 2047)));
      random_phase(PHASE_ITEMS);

      configure(random_id(), random_id(), random_id(), random_id(),
                CSR_DATA_WIDTH'($urandom_range(0, 100)));
      quiet = 1'b1;
      random_phase(PHASE_ITEMS);
      drain();
      quiet = 1'b0;

      configure(11'd0, 11'd1, 11'd2, 11'd3, 11'd5);
      random_phase(PHASE_ITEMS);

      drain();
      if (mismatch_count == 0 && commands_pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
